// ===== hdl/lifetime_histogram_stats_assert.svh =====
// Assertion macros for the lifetime histogram statistics block.
`ifndef LIFETIME_HISTOGRAM_STATS_ASSERT_SVH
`define LIFETIME_HISTOGRAM_STATS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lhs_pkg.sv =====
// Package with widths, binning constants and stream layout of the lifetime statistics block.
package lhs_pkg;

  localparam int LT_W         = 27;
  localparam int CNT_W        = 32;
  localparam int SUM_W        = 64;
  localparam int SQ_W         = 2 * LT_W;
  localparam int BIN_IDX_W    = 12;

  localparam int HIST_BINS    = 4096;
  localparam int BIN_WIDTH_US = 1000;
  localparam int BIN_W        = $clog2(HIST_BINS);

  // lifetimes at or above this value land in the last (overflow) bin
  localparam longint unsigned CLAMP_LT =
    longint'(HIST_BINS - 1) * longint'(BIN_WIDTH_US);
  localparam int CLAMP_LOG = $clog2(CLAMP_LT);
  localparam int DIV_N     = (CLAMP_LOG > LT_W) ? LT_W : ((CLAMP_LOG < 1) ? 1 : CLAMP_LOG);
  localparam int DIV_SHIFT = DIV_N + $clog2(BIN_WIDTH_US);
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_SHIFT) + longint'(BIN_WIDTH_US) - 64'd1) / longint'(BIN_WIDTH_US);
  localparam int RECIP_W   = DIV_N + 1;
  localparam int PROD_W    = DIV_N + RECIP_W + BIN_W;

  // input stream layout
  localparam int IN_TDATA_W = ((LT_W + 7) / 8) * 8;

  // output stream layout
  localparam int OUT_CNT_LSB    = 0;
  localparam int OUT_SUM_LSB    = OUT_CNT_LSB + CNT_W;
  localparam int OUT_SQ_LSB     = OUT_SUM_LSB + SUM_W;
  localparam int OUT_MIN_LSB    = OUT_SQ_LSB + SUM_W;
  localparam int OUT_MAX_LSB    = OUT_MIN_LSB + LT_W;
  localparam int OUT_BIN_LSB    = OUT_MAX_LSB + LT_W;
  localparam int OUT_BCNT_LSB   = OUT_BIN_LSB + BIN_IDX_W;
  localparam int OUT_FIELDS_W   = OUT_BCNT_LSB + CNT_W;
  localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

// ===== hdl/lhs_binner.sv =====
// Histogram bin selection: lifetime divided by the bin width, clamped into the last bin.
module lhs_binner
  import lhs_pkg::*;
(
  input  logic [LT_W-1:0]  lifetime,
  output logic [BIN_W-1:0] bin
);

  logic                clamp;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   quot;

  assign clamp = 64'(lifetime) >= CLAMP_LT;
  assign prod  = PROD_W'(lifetime[DIV_N-1:0]) * PROD_W'(RECIP_W'(RECIP));
  assign quot  = prod >> DIV_SHIFT;
  assign bin   = clamp ? BIN_W'(HIST_BINS - 1) : quot[BIN_W-1:0];

endmodule

// ===== hdl/lifetime_histogram_stats.sv =====
// Top level of the connection lifetime statistics block with histogram memory.
// Takes one connection record per cycle while in_tready is high and returns one result
// per record through stages s1, s2, s3 and the output register. Records flagged as having calls update
// the sample count, saturating sum and sum of squares, minimum, maximum and one bin of a
// 4096-entry histogram held in a single-port-write, registered-read memory; the bin is
// found by a reciprocal multiply and the read-modify-write of back-to-back records to the
// same bin is covered by forwarding the last written count. The sustained rate of one
// record per cycle is set by that one histogram write port. After reset the histogram is
// cleared one bin per cycle, during which in_tready stays low.
module lifetime_histogram_stats
  import lhs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [26:0] lifetime_us, rest zero
  input  logic [0:0]             in_tuser,   // [0] had_calls
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // sample_count, lifetime_sum, lifetime_sum_squares,
                                             // lifetime_min, lifetime_max, bin_index,
                                             // bin_count, zero fill
  output logic [0:0]             out_tuser   // [0] counted
);

  logic [CNT_W-1:0]  hist_mem [HIST_BINS];
  logic [CNT_W-1:0]  rd_data_r;

  logic              clr_active_r, clr_active_nxt;
  logic [BIN_W-1:0]  clr_addr_r, clr_addr_nxt;

  logic              s1_valid_r;
  logic [LT_W-1:0]   s1_lt_r;
  logic              s1_calls_r;
  logic [BIN_W-1:0]  s1_bin;
  logic [SQ_W-1:0]   s1_sq;

  logic              s2_valid_r;
  logic [LT_W-1:0]   s2_lt_r;
  logic              s2_calls_r;
  logic [SQ_W-1:0]   s2_sq_r;
  logic [BIN_W-1:0]  s2_bin_r;

  logic              s3_valid_r;
  logic [LT_W-1:0]   s3_lt_r;
  logic              s3_calls_r;
  logic [SQ_W-1:0]   s3_sq_r;
  logic [BIN_W-1:0]  s3_bin_r;

  logic              lw_valid_r;
  logic [BIN_W-1:0]  lw_bin_r;
  logic [CNT_W-1:0]  lw_cnt_r;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  sum_sq_r, sum_sq_nxt;
  logic [LT_W-1:0]   min_r, min_nxt;
  logic [LT_W-1:0]   max_r, max_nxt;

  logic [SUM_W:0]    sum_add;
  logic [SUM_W:0]    sq_add;
  logic [CNT_W-1:0]  bin_cur;
  logic [CNT_W-1:0]  bin_new;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_user_r;

  logic              out_load;
  logic              advance;
  logic              s3_move;
  logic              mem_we;
  logic [BIN_W-1:0]  mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;

  lhs_binner u_binner (
    .lifetime (s1_lt_r),
    .bin      (s1_bin)
  );

  assign s1_sq     = SQ_W'(s1_lt_r) * SQ_W'(s1_lt_r);

  assign out_load  = !out_valid_r || out_tready;
  assign advance   = !s3_valid_r || out_load;
  assign s3_move   = s3_valid_r && out_load;
  assign in_tready = advance && !clr_active_r;

  // forward the count written by the previous request to the same bin
  assign bin_cur = (lw_valid_r && (lw_bin_r == s3_bin_r)) ? lw_cnt_r : rd_data_r;
  assign bin_new = (bin_cur == '1) ? bin_cur : bin_cur + CNT_W'(1);

  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(s3_lt_r);
  assign sq_add  = {1'b0, sum_sq_r} + (SUM_W + 1)'(s3_sq_r);

  always_comb begin
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    sum_sq_nxt = sum_sq_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    if (s3_calls_r) begin
      count_nxt  = (count_r == '1) ? count_r : count_r + CNT_W'(1);
      sum_nxt    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      sum_sq_nxt = sq_add[SUM_W] ? '1 : sq_add[SUM_W-1:0];
      min_nxt    = (s3_lt_r < min_r) ? s3_lt_r : min_r;
      max_nxt    = (s3_lt_r > max_r) ? s3_lt_r : max_r;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[OUT_CNT_LSB +: CNT_W] = count_nxt;
    out_data_nxt[OUT_SUM_LSB +: SUM_W] = sum_nxt;
    out_data_nxt[OUT_SQ_LSB +: SUM_W]  = sum_sq_nxt;
    out_data_nxt[OUT_MIN_LSB +: LT_W]  = min_nxt;
    out_data_nxt[OUT_MAX_LSB +: LT_W]  = max_nxt;
    if (s3_calls_r) begin
      out_data_nxt[OUT_BIN_LSB +: BIN_IDX_W] = BIN_IDX_W'(s3_bin_r);
      out_data_nxt[OUT_BCNT_LSB +: CNT_W]    = bin_new;
    end
  end

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + BIN_W'(1);
      if (clr_addr_r == BIN_W'(HIST_BINS - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  assign mem_we    = clr_active_r || (s3_move && s3_calls_r);
  assign mem_waddr = clr_active_r ? clr_addr_r : s3_bin_r;
  assign mem_wdata = clr_active_r ? '0 : bin_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (advance) begin
      rd_data_r <= hist_mem[s2_bin_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      lw_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
      sum_r        <= '0;
      sum_sq_r     <= '0;
      min_r        <= '1;
      max_r        <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      if (advance) begin
        s1_valid_r <= in_tvalid && in_tready;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
        lw_valid_r <= s3_valid_r && s3_calls_r;
      end
      if (out_load) begin
        out_valid_r <= s3_valid_r;
      end
      if (s3_move) begin
        count_r  <= count_nxt;
        sum_r    <= sum_nxt;
        sum_sq_r <= sum_sq_nxt;
        min_r    <= min_nxt;
        max_r    <= max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_lt_r    <= in_tdata[LT_W-1:0];
      s1_calls_r <= in_tuser[0];
      s2_lt_r    <= s1_lt_r;
      s2_calls_r <= s1_calls_r;
      s2_sq_r    <= s1_sq;
      s2_bin_r   <= s1_bin;
      s3_lt_r    <= s2_lt_r;
      s3_calls_r <= s2_calls_r;
      s3_sq_r    <= s2_sq_r;
      s3_bin_r   <= s2_bin_r;
      lw_bin_r   <= s3_bin_r;
      lw_cnt_r   <= bin_new;
    end
    if (s3_move) begin
      out_data_r <= out_data_nxt;
      out_user_r <= s3_calls_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

endmodule

// ===== hdl/lhs_checker.sv =====
// Port-level checker for the lifetime statistics block, bound to the top level.
`include "lifetime_histogram_stats_assert.svh"

module lhs_checker
  import lhs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]             out_tuser
);

  `LHS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  `LHS_ASSERT_NOW(a_skip_no_bin, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[OUT_FIELDS_W-1:OUT_BIN_LSB] == '0, "uncounted result shows a bin")

  `LHS_ASSERT_NOW(a_counted_sane, clk, rst_n, out_tvalid && out_tuser[0], (out_tdata[OUT_BCNT_LSB +: CNT_W] != '0) && (out_tdata[OUT_CNT_LSB +: CNT_W] != '0) && (out_tdata[OUT_MIN_LSB +: LT_W] <= out_tdata[OUT_MAX_LSB +: LT_W]), "counted result inconsistent")

endmodule

bind lifetime_histogram_stats lhs_checker u_lhs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
